/* rtl/gsc_pkg.sv */
package gsc_pkg;

    // Fixed point format: samples are Q31.16, costs are Q47.16.
    localparam int FRAC_BITS = 16;

    // Dimensions counted per segment; the count sticks at this value.
    localparam int MAX_DIMS = 16;
    localparam int DIM_W    = $clog2(MAX_DIMS + 1);

    // Field widths of one input word and one result word.
    localparam int SUM_W   = 48;
    localparam int SQ_W    = 47;
    localparam int IDX_W   = 16;
    localparam int COST_W  = 64;
    localparam int LEN_W   = IDX_W + 1;
    localparam int DIFF_W  = SUM_W + 1;

    // Packed stream widths, padded to whole bytes.
    localparam int IN_BITS  = 2 * SUM_W + 2 * SQ_W + 2 * IDX_W + COST_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = SUM_W + 2 * COST_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // Bit offsets of the input fields inside s_tdata.
    localparam int OFS_SE    = 0;
    localparam int OFS_SS    = OFS_SE + SUM_W;
    localparam int OFS_QE    = OFS_SS + SUM_W;
    localparam int OFS_QS    = OFS_QE + SQ_W;
    localparam int OFS_ST    = OFS_QS + SQ_W;
    localparam int OFS_EN    = OFS_ST + IDX_W;
    localparam int OFS_PRIOR = OFS_EN + IDX_W;

    // Saturation limits.
    localparam logic signed [COST_W-1:0] S64_MAX = {1'b0, {(COST_W-1){1'b1}}};
    localparam logic signed [COST_W-1:0] S64_MIN = {1'b1, {(COST_W-1){1'b0}}};
    localparam logic signed [SUM_W-1:0]  S48_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0]  S48_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // Width of the multiplier product accumulator.
    localparam int PROD_W = 96;

endpackage

/* rtl/gaussian_segment_cost_core.sv */
// Least-squares segment cost core. Each input word carries one dimension of a
// candidate segment (prefix sums of values and squares at start and end+1, the
// segment bounds and the prior cost, with s_tlast marking the final dimension).
// Each word yields one result word with the dimension mean truncated toward
// zero; on the final dimension the result also carries the variance cost and
// that cost plus the prior cost, with m_tlast set, and the accumulators clear
// for the next segment. m_tuser reports any saturation seen in the segment so
// far. The core works on one word at a time through a small sequencer around
// one shared 65-bit saturating adder, one 32x32 multiplier and a radix-2
// restoring divider. The divider runs 49 steps for each word; on the final
// dimension the sequencer goes on to form the length product and the two cost
// sums before registering the result. A new word is accepted in the cycle
// after the result is registered, while the result may still wait in the
// output register.
module gaussian_segment_cost_core
    import gsc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // Input channel.
    input  logic              s_tvalid,
    output logic              s_tready,
    // Fields from bit 0 up: sum_at_end[48], sum_at_start[48], sq_at_end[47],
    // sq_at_start[47], seg_start[16], seg_end[16], prior_cost[64], zero pad.
    input  logic [IN_W-1:0]   s_tdata,
    input  logic              s_tlast,
    // Result channel.
    output logic              m_tvalid,
    input  logic              m_tready,
    // Fields from bit 0 up: mean_value[48], var_cost[64], total_cost[64].
    output logic [OUT_W-1:0]  m_tdata,
    output logic              m_tlast,
    // Fields from bit 0 up: saturated[1].
    output logic              m_tuser
);

    // Sequencer states.
    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_DIFF  = 5'd1;
    localparam logic [4:0] ST_ABS   = 5'd2;
    localparam logic [4:0] ST_DIV   = 5'd3;
    localparam logic [4:0] ST_MEAN  = 5'd4;
    localparam logic [4:0] ST_SQ0   = 5'd5;
    localparam logic [4:0] ST_SQ1   = 5'd6;
    localparam logic [4:0] ST_SQ2   = 5'd7;
    localparam logic [4:0] ST_SQ3   = 5'd8;
    localparam logic [4:0] ST_ACCMS = 5'd9;
    localparam logic [4:0] ST_SUBQ  = 5'd10;
    localparam logic [4:0] ST_ACCSD = 5'd11;
    localparam logic [4:0] ST_LM0   = 5'd12;
    localparam logic [4:0] ST_LM1   = 5'd13;
    localparam logic [4:0] ST_LM2   = 5'd14;
    localparam logic [4:0] ST_VAR   = 5'd15;
    localparam logic [4:0] ST_TOT   = 5'd16;
    localparam logic [4:0] ST_FIN   = 5'd17;

    localparam int CNT_W = $clog2(DIFF_W);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIFF_W - 1);
    localparam logic [SUM_W-1:0] MAG_MAX_POS = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] MAG_MAX_NEG = {1'b1, {(SUM_W-1){1'b0}}};

    logic [4:0]               state_reg, state_next;

    // Latched input word.
    logic signed [SUM_W-1:0]  se_reg, ss_reg;
    logic [SQ_W-1:0]          qe_reg, qs_reg;
    logic [LEN_W-1:0]         len_reg;
    logic signed [COST_W-1:0] prior_reg;
    logic                     last_reg;

    // Segment accumulators.
    logic signed [COST_W-1:0] mean_sq_acc_reg, sq_diff_acc_reg;
    logic                     sat_flag_reg;
    logic [DIM_W-1:0]         dim_count_reg;

    // Working registers.
    logic signed [COST_W-1:0] tmp_reg;
    logic [DIFF_W-1:0]        quo_reg;
    logic [LEN_W-1:0]         rem_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic                     neg_reg;
    logic signed [SUM_W-1:0]  mean_reg;
    logic [SUM_W-1:0]         mag_reg;
    logic [63:0]              pp_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic signed [COST_W-1:0] var_reg, tot_reg;

    // Output register.
    logic                     m_valid_reg;
    logic [OUT_W-1:0]         m_data_reg;
    logic                     m_last_reg;
    logic                     m_user_reg;

    // Shared adder signals.
    logic signed [COST_W:0]   add_a, add_b, add_sum;
    logic                     add_sub, add_ovf;
    logic signed [COST_W-1:0] add_sat;

    // Shared multiplier signals.
    logic [31:0]              mul_a, mul_b;
    logic [PROD_W-1:0]        prod_addend;

    // Divider step signals.
    logic [LEN_W:0]           trial;
    logic                     trial_ge;
    logic [LEN_W:0]           trial_rem;

    // Scaled products with their saturation.
    logic [PROD_W-1:0]        prod_shr;
    logic                     sq_sat, len_sat;
    logic signed [COST_W-1:0] sq_val, len_val;

    // Mean saturation.
    logic                     big_pos, big_neg;

    logic                     s_hs, out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_hs     = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

    // Operand selection for the shared saturating adder.
    always_comb begin
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
        case (state_reg)
            ST_DIFF: begin
                add_a   = (COST_W+1)'(se_reg);
                add_b   = (COST_W+1)'(ss_reg);
                add_sub = 1'b1;
            end
            ST_ABS: begin
                add_b   = (COST_W+1)'(tmp_reg);
                add_sub = 1'b1;
            end
            ST_MEAN: begin
                add_b   = $signed({{(COST_W+1-DIFF_W){1'b0}}, quo_reg});
                add_sub = 1'b1;
            end
            ST_ACCMS: begin
                add_a = (COST_W+1)'(mean_sq_acc_reg);
                add_b = (COST_W+1)'(sq_val);
            end
            ST_SUBQ: begin
                add_a   = $signed({{(COST_W+1-SQ_W){1'b0}}, qe_reg});
                add_b   = $signed({{(COST_W+1-SQ_W){1'b0}}, qs_reg});
                add_sub = 1'b1;
            end
            ST_ACCSD: begin
                add_a = (COST_W+1)'(sq_diff_acc_reg);
                add_b = (COST_W+1)'(tmp_reg);
            end
            ST_VAR: begin
                add_a   = (COST_W+1)'(sq_diff_acc_reg);
                add_b   = (COST_W+1)'(len_val);
                add_sub = 1'b1;
            end
            ST_TOT: begin
                add_a = (COST_W+1)'(var_reg);
                add_b = (COST_W+1)'(prior_reg);
            end
            default: begin
                add_a = '0;
            end
        endcase
        add_sum = add_sub ? (add_a - add_b) : (add_a + add_b);
        add_ovf = add_sum[COST_W] ^ add_sum[COST_W-1];
        if (add_ovf) begin
            add_sat = add_sum[COST_W] ? S64_MIN : S64_MAX;
        end else begin
            add_sat = add_sum[COST_W-1:0];
        end
    end

    // Operand selection for the shared multiplier and partial product placement.
    always_comb begin
        mul_a       = '0;
        mul_b       = '0;
        prod_addend = '0;
        case (state_reg)
            ST_SQ0: begin
                mul_a = {8'd0, mag_reg[23:0]};
                mul_b = {8'd0, mag_reg[23:0]};
            end
            ST_SQ1: begin
                mul_a       = {8'd0, mag_reg[23:0]};
                mul_b       = {8'd0, mag_reg[47:24]};
                prod_addend = {32'd0, pp_reg};
            end
            ST_SQ2: begin
                mul_a       = {8'd0, mag_reg[47:24]};
                mul_b       = {8'd0, mag_reg[47:24]};
                prod_addend = {7'd0, pp_reg, 25'd0};
            end
            ST_SQ3: begin
                prod_addend = {pp_reg[47:0], 48'd0};
            end
            ST_LM0: begin
                mul_a = {{(32-LEN_W){1'b0}}, len_reg};
                mul_b = mean_sq_acc_reg[31:0];
            end
            ST_LM1: begin
                mul_a       = {{(32-LEN_W){1'b0}}, len_reg};
                mul_b       = {1'b0, mean_sq_acc_reg[62:32]};
                prod_addend = {32'd0, pp_reg};
            end
            ST_LM2: begin
                prod_addend = {pp_reg, 32'd0};
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    // One restoring division step.
    always_comb begin
        trial     = {rem_reg, quo_reg[DIFF_W-1]};
        trial_ge  = (trial >= {1'b0, len_reg});
        trial_rem = trial - {1'b0, len_reg};
    end

    // Saturated views of the product accumulator.
    always_comb begin
        prod_shr = prod_reg >> FRAC_BITS;
        sq_sat   = |prod_shr[PROD_W-1:COST_W-1];
        sq_val   = sq_sat ? S64_MAX : $signed({1'b0, prod_shr[COST_W-2:0]});
        len_sat  = |prod_reg[PROD_W-1:COST_W-1];
        len_val  = len_sat ? S64_MAX : $signed({1'b0, prod_reg[COST_W-2:0]});
        big_pos  = !neg_reg && (quo_reg > {1'b0, MAG_MAX_POS});
        big_neg  = neg_reg && (quo_reg > {1'b0, MAG_MAX_NEG});
    end

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_hs) state_next = ST_DIFF;
            ST_DIFF:  state_next = ST_ABS;
            ST_ABS:   state_next = ST_DIV;
            ST_DIV:   if (cnt_reg == '0) state_next = ST_MEAN;
            ST_MEAN:  state_next = ST_SQ0;
            ST_SQ0:   state_next = ST_SQ1;
            ST_SQ1:   state_next = ST_SQ2;
            ST_SQ2:   state_next = ST_SQ3;
            ST_SQ3:   state_next = ST_ACCMS;
            ST_ACCMS: state_next = ST_SUBQ;
            ST_SUBQ:  state_next = ST_ACCSD;
            ST_ACCSD: state_next = last_reg ? ST_LM0 : ST_FIN;
            ST_LM0:   state_next = ST_LM1;
            ST_LM1:   state_next = ST_LM2;
            ST_LM2:   state_next = ST_VAR;
            ST_VAR:   state_next = ST_TOT;
            ST_TOT:   state_next = ST_FIN;
            ST_FIN:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Control state and accumulators.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            mean_sq_acc_reg <= '0;
            sq_diff_acc_reg <= '0;
            sat_flag_reg    <= 1'b0;
            dim_count_reg   <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_MEAN: begin
                    if (big_pos || big_neg) sat_flag_reg <= 1'b1;
                end
                ST_ACCMS: begin
                    mean_sq_acc_reg <= add_sat;
                    if (sq_sat || add_ovf) sat_flag_reg <= 1'b1;
                end
                ST_ACCSD: begin
                    sq_diff_acc_reg <= add_sat;
                    if (add_ovf) sat_flag_reg <= 1'b1;
                    if (dim_count_reg < DIM_W'(MAX_DIMS)) begin
                        dim_count_reg <= dim_count_reg + 1'b1;
                    end
                end
                ST_VAR: begin
                    if (len_sat || add_ovf) sat_flag_reg <= 1'b1;
                end
                ST_TOT: begin
                    if (add_ovf) sat_flag_reg <= 1'b1;
                end
                ST_FIN: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        if (last_reg) begin
                            mean_sq_acc_reg <= '0;
                            sq_diff_acc_reg <= '0;
                            sat_flag_reg    <= 1'b0;
                            dim_count_reg   <= '0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        pp_reg <= mul_a * mul_b;
        case (state_reg)
            ST_IDLE: begin
                if (s_hs) begin
                    se_reg    <= s_tdata[OFS_SE +: SUM_W];
                    ss_reg    <= s_tdata[OFS_SS +: SUM_W];
                    qe_reg    <= s_tdata[OFS_QE +: SQ_W];
                    qs_reg    <= s_tdata[OFS_QS +: SQ_W];
                    len_reg   <= {1'b0, s_tdata[OFS_EN +: IDX_W] - s_tdata[OFS_ST +: IDX_W]}
                                 + LEN_W'(1);
                    prior_reg <= s_tdata[OFS_PRIOR +: COST_W];
                    last_reg  <= s_tlast;
                end
            end
            ST_DIFF: begin
                tmp_reg <= add_sat;
            end
            ST_ABS: begin
                neg_reg <= tmp_reg[COST_W-1];
                quo_reg <= tmp_reg[COST_W-1] ? add_sat[DIFF_W-1:0] : tmp_reg[DIFF_W-1:0];
                rem_reg <= '0;
                cnt_reg <= DIV_LAST;
            end
            ST_DIV: begin
                if (trial_ge) begin
                    rem_reg <= trial_rem[LEN_W-1:0];
                end else begin
                    rem_reg <= trial[LEN_W-1:0];
                end
                quo_reg <= {quo_reg[DIFF_W-2:0], trial_ge};
                cnt_reg <= cnt_reg - 1'b1;
            end
            ST_MEAN: begin
                if (big_pos) begin
                    mean_reg <= S48_MAX;
                    mag_reg  <= MAG_MAX_POS;
                end else if (big_neg) begin
                    mean_reg <= S48_MIN;
                    mag_reg  <= MAG_MAX_NEG;
                end else begin
                    mean_reg <= neg_reg ? add_sat[SUM_W-1:0] : quo_reg[SUM_W-1:0];
                    mag_reg  <= quo_reg[SUM_W-1:0];
                end
            end
            ST_SQ0, ST_LM0: begin
                prod_reg <= '0;
            end
            ST_SQ1, ST_SQ2, ST_SQ3, ST_LM1, ST_LM2: begin
                prod_reg <= prod_reg + prod_addend;
            end
            ST_SUBQ: begin
                tmp_reg <= add_sat;
            end
            ST_VAR: begin
                var_reg <= add_sat;
            end
            ST_TOT: begin
                tot_reg <= add_sat;
            end
            ST_FIN: begin
                if (out_free) begin
                    m_data_reg <= {last_reg ? tot_reg : '0, last_reg ? var_reg : '0, mean_reg};
                    m_last_reg <= last_reg;
                    m_user_reg <= sat_flag_reg;
                end
            end
            default: begin
            end
        endcase
    end

endmodule
